>>> rtl/core/rsma_pkg.sv
// Shared types and constants for the running-sum moving average.
`default_nettype none

package rsma_pkg;

   localparam int SAMPLE_W = 32;
   localparam int COUNT_W  = 9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;
      logic accum;
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/rsma_req_if.sv
// Request channel: one signed sample per transfer.
`default_nettype none

interface rsma_req_if import rsma_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rsma_rsp_if.sv
// Response channel: average and count of held samples per transfer.
`default_nettype none

interface rsma_rsp_if import rsma_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] average;
   logic        [COUNT_W-1:0]  samples_held;

   modport source (output valid, output average, output samples_held, input ready);
   modport sink   (input valid, input average, input samples_held, output ready);
endinterface

`default_nettype wire

>>> rtl/core/running_sum_moving_average.sv
// A sample is taken while idle, added to the running sum, then divided by the count held;
// no new sample is taken until its result has gone to the output register. The restoring
// divider produces one quotient bit per cycle over the sum width.
// Reset: synchronous; window = 1, count, slot and sum cleared, no result pending.
// A window write restarts the filter; the ring needs no clearing pass.
`default_nettype none

module running_sum_moving_average import rsma_pkg::*; #(
   parameter int MAX_WINDOW = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   rsma_req_if.sink                req_chan,
   rsma_rsp_if.source              rsp_chan,
   input  wire logic               csr_we,
   input  wire logic [COUNT_W-1:0] csr_wdata
);

   localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int EFF_MAX = (MAX_WINDOW > 511) ? 511 : MAX_WINDOW;
   localparam int SUM_W   = SAMPLE_W + ((EFF_MAX > 1) ? $clog2(EFF_MAX) : 0);
   localparam int STEP_W  = $clog2(SUM_W + 1);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;
   logic signed [SAMPLE_W-1:0] rsp_average;
   logic [COUNT_W-1:0]         rsp_samples_held;

   rsma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rsma_datapath #(
      .MAX_WINDOW (MAX_WINDOW),
      .IDX_W      (IDX_W),
      .SUM_W      (SUM_W),
      .STEP_W     (STEP_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_sample       (req_chan.sample),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_valid),
      .rsp_average      (rsp_average),
      .rsp_samples_held (rsp_samples_held)
   );

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.average      = rsp_average;
   assign rsp_chan.samples_held = rsp_samples_held;

endmodule

`default_nettype wire

>>> rtl/core/rsma_datapath.sv
// Datapath: sample ring, running sum, restoring divider and output register.
`default_nettype none

module rsma_datapath import rsma_pkg::*; #(
   parameter int MAX_WINDOW = 256,
   parameter int IDX_W      = 8,
   parameter int SUM_W      = 40,
   parameter int STEP_W     = 6
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [COUNT_W-1:0]         csr_wdata,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire cmd_type                    cmd,
   output      status_type                 status,
   input  wire logic                       rsp_ready,
   output      logic                       rsp_valid,
   output      logic signed [SAMPLE_W-1:0] rsp_average,
   output      logic [COUNT_W-1:0]         rsp_samples_held
);

   localparam int CMP_W = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;

   logic [COUNT_W-1:0]         win_ff, win_in;
   logic [COUNT_W-1:0]         held_ff, held_in;
   logic [IDX_W-1:0]           slot_ff, slot_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] old_ff;
   logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];

   logic [COUNT_W-1:0]         rem_ff, rem_in;
   logic [SUM_W-1:0]           quo_ff, quo_in;
   logic                       neg_ff, neg_in;
   logic [STEP_W-1:0]          step_ff, step_in;

   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] avg_ff, avg_in;
   logic [COUNT_W-1:0]         cnt_ff, cnt_in;

   logic                       full;
   logic                       slot_wrap;
   logic signed [SUM_W-1:0]    old_term;
   logic [COUNT_W:0]           shifted;
   logic                       fits;
   logic [SUM_W-1:0]           res;

   // window register, clamped on write
   always_comb begin
      win_in = win_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            win_in = COUNT_W'(1);
         end else if (32'(csr_wdata) > 32'(MAX_WINDOW)) begin
            win_in = COUNT_W'(MAX_WINDOW);
         end else begin
            win_in = csr_wdata;
         end
      end
   end

   // running sum update; once full the oldest sample leaves the sum
   assign full      = (held_ff == win_ff);
   assign slot_wrap = (CMP_W'(slot_ff) + CMP_W'(1) == CMP_W'(win_ff));
   assign old_term  = full ? SUM_W'(old_ff) : '0;

   always_comb begin
      held_in = held_ff;
      slot_in = slot_ff;
      sum_in  = sum_ff;
      if (csr_we) begin
         held_in = '0;
         slot_in = '0;
         sum_in  = '0;
      end else if (cmd.accum) begin
         held_in = full ? held_ff : held_ff + COUNT_W'(1);
         slot_in = slot_wrap ? '0 : slot_ff + IDX_W'(1);
         sum_in  = sum_ff + SUM_W'(sample_ff) - old_term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= COUNT_W'(1);
         held_ff <= '0;
         slot_ff <= '0;
         sum_ff  <= '0;
      end else begin
         win_ff  <= win_in;
         held_ff <= held_in;
         slot_ff <= slot_in;
         sum_ff  <= sum_in;
      end
   end

   // ring memory: read the slot about to be overwritten at the input transfer
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sample_ff <= req_sample;
         old_ff    <= ring[slot_ff];
      end
      if (cmd.accum) begin
         ring[slot_ff] <= sample_ff;
      end
   end

   // restoring divider on the magnitude of the sum, one quotient bit a cycle
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign fits    = (shifted >= {1'b0, held_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      if (cmd.load) begin
         neg_in  = sum_ff[SUM_W-1];
         quo_in  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         rem_in  = '0;
         step_in = STEP_W'(SUM_W);
      end else if (cmd.step) begin
         rem_in  = fits ? COUNT_W'(shifted - {1'b0, held_ff}) : shifted[COUNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   // output register
   assign res = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;

   always_comb begin
      avg_in       = avg_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         avg_in       = res[SAMPLE_W-1:0];
         cnt_in       = held_ff;
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff <= avg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign status = '{div_last: (step_ff == STEP_W'(1)),
                     out_free: (!out_valid_ff || rsp_ready)};

   assign rsp_valid        = out_valid_ff;
   assign rsp_average      = avg_ff;
   assign rsp_samples_held = cnt_ff;

   a_held_in_window: assert property (@(posedge clock) disable iff (reset)
      held_ff <= win_ff)
      else $error("held count exceeds window");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> out_valid_ff)
      else $error("emitted result not presented");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> cnt_ff != '0)
      else $error("result with zero samples held");

   a_accum_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.accum && !csr_we |=> held_ff != '0)
      else $error("accumulate left count at zero");

endmodule

`default_nettype wire

>>> rtl/core/rsma_ctrl.sv
// Controller: sequences fetch, sum update, division and result hand-off.
`default_nettype none

module rsma_ctrl import rsma_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire status_type status,
   output      cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_div_to_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE && status.div_last |=> state_ff == ST_EMIT)
      else $error("divider finish did not lead to emit");

endmodule

`default_nettype wire
